/* rtl/core/stevq_pkg.sv */
// Shared types, codes and helpers of the sorted timer event queue.
package stevq_pkg;

    // Time base and command field widths
    localparam int TIME_W    = 32;
    localparam int DELAY_W   = 31;
    localparam int FUNC_W    = 2;
    localparam int KIND_W    = 2;
    localparam int STATUS_W  = 3;

    // Most entries popped by one tick, and the width of the pop counter
    localparam int MAX_RESULTS = 16;
    localparam int NPOP_W      = $clog2(MAX_RESULTS + 1);

    typedef logic [TIME_W-1:0] time_t;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ADD  = 2'd0,
        FUNC_DEL  = 2'd1,
        FUNC_TICK = 2'd2
    } func_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_ADD  = 2'd0,
        KIND_DEL  = 2'd1,
        KIND_TICK = 2'd2
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_DUP      = 3'd1,
        ST_FULL     = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_NOTFOUND = 3'd4,
        ST_EXPIRED  = 3'd5,
        ST_NONE     = 3'd6
    } status_t;

    // True when a is strictly earlier than b, by the sign of the difference
    function automatic logic earlier(input time_t a, input time_t b);
        time_t diff;
        diff = a - b;
        return diff[TIME_W-1];
    endfunction

endpackage

/* rtl/core/stevq_cmd_if.sv */
// Command channel of the timer event queue: valid/ready with one command a beat.
interface stevq_cmd_if #(
    parameter int KEY_WIDTH = 16
);
    logic                           valid;
    logic                           ready;
    logic [stevq_pkg::FUNC_W-1:0]   func;
    logic [KEY_WIDTH-1:0]           event_key;
    logic [stevq_pkg::DELAY_W-1:0]  delay_ms;

    modport source (output valid, output func, output event_key, output delay_ms,
                    input ready);
    modport sink   (input valid, input func, input event_key, input delay_ms,
                    output ready);
endinterface

/* rtl/core/stevq_rsp_if.sv */
// Response channel of the timer event queue: valid/ready with one result a beat.
interface stevq_rsp_if #(
    parameter int KEY_WIDTH = 16
);
    logic                            valid;
    logic                            ready;
    logic [stevq_pkg::KIND_W-1:0]    kind;
    logic [stevq_pkg::STATUS_W-1:0]  status;
    logic [KEY_WIDTH-1:0]            event_key_res;
    logic                            last;

    modport source (output valid, output kind, output status, output event_key_res,
                    output last, input ready);
    modport sink   (input valid, input kind, input status, input event_key_res,
                    input last, output ready);
endinterface

/* rtl/core/sorted_timer_event_queue_core.sv */
// Sorted timer event queue: a deadline-ordered table of timer events in one RAM.
//
// Usage: commands arrive on cmd (add, delete, tick); results leave on rsp, one
// beat each, with last set on the final beat caused by a command. An item is
// taken when valid and ready are both high. cmd.ready is high only between
// commands: the block works on one command at a time.
// The table is a circular buffer in one RAM with a registered read;
// entries are kept in deadline order from the head pointer.
// Steps of each command (N = entries held, M = entries moved):
//   add    : written directly on an empty table; otherwise a scan of the N
//            entries, then a duplicate or full report, or the write, after
//            M entries move up when the new entry is not the last.
//   delete : empty table reported without a scan; otherwise a scan, then
//            a not-found report or a move of M entries down.
//   tick   : one beat when nothing expires; K expiries give K beats.
// The scan and the entry moves each take one RAM access a cycle. The block
// returns to idle as the last beat loads, while that beat waits in rsp.
// Reset empties the table and clears the millisecond counter at once; no
// clearing pass is run. When rsp is stalled, the result waits in the output
// register, and the block waits before loading another beat until it is taken.
module sorted_timer_event_queue_core #(
    parameter int DEPTH     = 16,
    parameter int KEY_WIDTH = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    stevq_cmd_if.sink  cmd,
    stevq_rsp_if.source rsp
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;
    localparam int TW = stevq_pkg::TIME_W;
    localparam int EW = TW + KEY_WIDTH;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SCAN  = 6'b000010,
        S_SHIFT = 6'b000100,
        S_WRITE = 6'b001000,
        S_RESP  = 6'b010000,
        S_TICK  = 6'b100000
    } state_t;

    state_t                        state_reg, state_next;
    logic [CW-1:0]                 count_reg, count_next;
    logic [AW-1:0]                 head_reg, head_next;
    stevq_pkg::time_t              now_reg, now_next;
    stevq_pkg::func_t              op_reg, op_next;
    logic [KEY_WIDTH-1:0]          key_reg, key_next;
    stevq_pkg::time_t              exp_reg, exp_next;
    logic                          chk_v_reg, chk_v_next;
    logic [CW-1:0]                 chk_idx_reg, chk_idx_next;
    logic [CW-1:0]                 iss_cnt_reg, iss_cnt_next;
    logic [AW-1:0]                 iss_ptr_reg, iss_ptr_next;
    logic                          found_reg, found_next;
    logic [CW-1:0]                 found_idx_reg, found_idx_next;
    logic                          pos_found_reg, pos_found_next;
    logic [CW-1:0]                 pos_reg, pos_next;
    logic [AW-1:0]                 rd_ptr_reg, rd_ptr_next;
    logic [AW-1:0]                 wr_ptr_reg, wr_ptr_next;
    logic                          wv_reg, wv_next;
    logic [CW-1:0]                 mv_reg, mv_next;
    logic                          up_reg, up_next;
    logic                          pend_v_reg, pend_v_next;
    logic [KEY_WIDTH-1:0]          pend_key_reg, pend_key_next;
    logic [stevq_pkg::NPOP_W-1:0]  npop_reg, npop_next;
    stevq_pkg::status_t            resp_status_reg, resp_status_next;
    logic                          out_valid_reg, out_valid_next;
    stevq_pkg::kind_t              out_kind_reg, out_kind_next;
    stevq_pkg::status_t            out_status_reg, out_status_next;
    logic [KEY_WIDTH-1:0]          out_key_reg, out_key_next;
    logic                          out_last_reg, out_last_next;

    logic                          ram_wr_en;
    logic [AW-1:0]                 ram_wr_addr;
    logic [EW-1:0]                 ram_wr_data;
    logic                          ram_rd_en;
    logic [AW-1:0]                 ram_rd_addr;
    logic [EW-1:0]                 ram_rd_data;

    stevq_pkg::time_t              rd_time;
    logic [KEY_WIDTH-1:0]          rd_key;
    stevq_pkg::func_t              cmd_func;
    logic                          out_free;
    logic                          expired;

    // Step a physical pointer forward or back around the ring
    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    function automatic logic [AW-1:0] wrap_dec(input logic [AW-1:0] p);
        return (p == '0) ? AW'(DEPTH - 1) : p - AW'(1);
    endfunction

    // Map a position in deadline order to a RAM address
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                           input logic [CW-1:0] l);
        logic [SW-1:0] s;
        s = SW'(head) + SW'(l);
        if (s >= SW'(DEPTH))
        begin
            s = s - SW'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    stevq_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign rd_time  = ram_rd_data[KEY_WIDTH +: TW];
    assign rd_key   = ram_rd_data[KEY_WIDTH-1:0];
    assign cmd_func = stevq_pkg::func_t'(cmd.func);
    assign out_free = !out_valid_reg || rsp.ready;
    assign expired  = (count_reg != '0)
                      && (npop_reg < stevq_pkg::NPOP_W'(stevq_pkg::MAX_RESULTS))
                      && stevq_pkg::earlier(rd_time, now_reg);

    assign cmd.ready         = (state_reg == S_IDLE);
    assign rsp.valid         = out_valid_reg;
    assign rsp.kind          = out_kind_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.event_key_res = out_key_reg;
    assign rsp.last          = out_last_reg;

    // Sequence each command through scan, move, write and respond, or tick pops
    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        head_next        = head_reg;
        now_next         = now_reg;
        op_next          = op_reg;
        key_next         = key_reg;
        exp_next         = exp_reg;
        chk_v_next       = chk_v_reg;
        chk_idx_next     = chk_idx_reg;
        iss_cnt_next     = iss_cnt_reg;
        iss_ptr_next     = iss_ptr_reg;
        found_next       = found_reg;
        found_idx_next   = found_idx_reg;
        pos_found_next   = pos_found_reg;
        pos_next         = pos_reg;
        rd_ptr_next      = rd_ptr_reg;
        wr_ptr_next      = wr_ptr_reg;
        wv_next          = wv_reg;
        mv_next          = mv_reg;
        up_next          = up_reg;
        pend_v_next      = pend_v_reg;
        pend_key_next    = pend_key_reg;
        npop_next        = npop_reg;
        resp_status_next = resp_status_reg;
        out_valid_next   = out_valid_reg && !rsp.ready;
        out_kind_next    = out_kind_reg;
        out_status_next  = out_status_reg;
        out_key_next     = out_key_reg;
        out_last_next    = out_last_reg;
        ram_wr_en        = 1'b0;
        ram_wr_addr      = wr_ptr_reg;
        ram_wr_data      = {rd_time, rd_key};
        ram_rd_en        = 1'b0;
        ram_rd_addr      = rd_ptr_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    op_next  = cmd_func;
                    key_next = cmd.event_key;
                    exp_next = now_reg + TW'(cmd.delay_ms);
                    unique case (cmd_func)
                        stevq_pkg::FUNC_ADD, stevq_pkg::FUNC_DEL:
                        begin
                            if (count_reg == '0)
                            begin
                                // Empty table: add goes straight in, delete reports
                                pos_next         = '0;
                                resp_status_next = stevq_pkg::ST_EMPTY;
                                state_next = (cmd_func == stevq_pkg::FUNC_ADD) ?
                                             S_WRITE : S_RESP;
                            end
                            else
                            begin
                                ram_rd_en      = 1'b1;
                                ram_rd_addr    = head_reg;
                                iss_cnt_next   = CW'(1);
                                iss_ptr_next   = wrap_inc(head_reg);
                                chk_v_next     = 1'b1;
                                chk_idx_next   = '0;
                                found_next     = 1'b0;
                                pos_found_next = 1'b0;
                                pos_next       = count_reg;
                                state_next     = S_SCAN;
                            end
                        end
                        stevq_pkg::FUNC_TICK:
                        begin
                            now_next    = now_reg + TW'(1);
                            ram_rd_en   = 1'b1;
                            ram_rd_addr = head_reg;
                            npop_next   = '0;
                            pend_v_next = 1'b0;
                            state_next  = S_TICK;
                        end
                        default:
                        begin
                            // Unused code: drop the command
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                if (chk_v_reg)
                begin
                    // Check one entry while the next read is in flight
                    if (!found_reg && (rd_key == key_reg))
                    begin
                        found_next     = 1'b1;
                        found_idx_next = chk_idx_reg;
                    end
                    if (!pos_found_reg && stevq_pkg::earlier(exp_reg, rd_time))
                    begin
                        pos_found_next = 1'b1;
                        pos_next       = chk_idx_reg;
                    end
                    if (iss_cnt_reg < count_reg)
                    begin
                        ram_rd_en    = 1'b1;
                        ram_rd_addr  = iss_ptr_reg;
                        iss_ptr_next = wrap_inc(iss_ptr_reg);
                        iss_cnt_next = iss_cnt_reg + CW'(1);
                        chk_v_next   = 1'b1;
                        chk_idx_next = iss_cnt_reg;
                    end
                    else
                    begin
                        chk_v_next = 1'b0;
                    end
                end
                else if (op_reg == stevq_pkg::FUNC_ADD)
                begin
                    wv_next = 1'b0;
                    if (found_reg)
                    begin
                        resp_status_next = stevq_pkg::ST_DUP;
                        state_next       = S_RESP;
                    end
                    else if (count_reg == CW'(DEPTH))
                    begin
                        resp_status_next = stevq_pkg::ST_FULL;
                        state_next       = S_RESP;
                    end
                    else if (pos_reg == count_reg)
                    begin
                        state_next = S_WRITE;
                    end
                    else
                    begin
                        // Open a slot: move the later entries up by one
                        up_next     = 1'b1;
                        rd_ptr_next = phys(head_reg, count_reg - CW'(1));
                        mv_next     = count_reg - pos_reg;
                        state_next  = S_SHIFT;
                    end
                end
                else
                begin
                    wv_next = 1'b0;
                    if (!found_reg)
                    begin
                        resp_status_next = stevq_pkg::ST_NOTFOUND;
                        state_next       = S_RESP;
                    end
                    else
                    begin
                        // Close the gap: move the later entries down by one
                        up_next     = 1'b0;
                        rd_ptr_next = phys(head_reg, found_idx_reg + CW'(1));
                        mv_next     = count_reg - CW'(1) - found_idx_reg;
                        state_next  = S_SHIFT;
                    end
                end
            end

            S_SHIFT:
            begin
                // Write back the entry read in the previous cycle
                ram_wr_en   = wv_reg;
                ram_wr_addr = wr_ptr_reg;
                ram_wr_data = {rd_time, rd_key};
                if (mv_reg != '0)
                begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = rd_ptr_reg;
                    wr_ptr_next = up_reg ? wrap_inc(rd_ptr_reg) : wrap_dec(rd_ptr_reg);
                    rd_ptr_next = up_reg ? wrap_dec(rd_ptr_reg) : wrap_inc(rd_ptr_reg);
                    wv_next     = 1'b1;
                    mv_next     = mv_reg - CW'(1);
                end
                else
                begin
                    wv_next = 1'b0;
                    if (up_reg)
                    begin
                        state_next = S_WRITE;
                    end
                    else
                    begin
                        count_next       = count_reg - CW'(1);
                        resp_status_next = stevq_pkg::ST_OK;
                        state_next       = S_RESP;
                    end
                end
            end

            S_WRITE:
            begin
                ram_wr_en        = 1'b1;
                ram_wr_addr      = phys(head_reg, pos_reg);
                ram_wr_data      = {exp_reg, key_reg};
                count_next       = count_reg + CW'(1);
                resp_status_next = stevq_pkg::ST_OK;
                state_next       = S_RESP;
            end

            S_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_kind_next   = (op_reg == stevq_pkg::FUNC_ADD) ?
                                      stevq_pkg::KIND_ADD : stevq_pkg::KIND_DEL;
                    out_status_next = resp_status_reg;
                    out_key_next    = key_reg;
                    out_last_next   = 1'b1;
                    state_next      = S_IDLE;
                end
            end

            S_TICK:
            begin
                if (out_free)
                begin
                    if (expired)
                    begin
                        // Pop the head; send the previous pop now that more follow
                        if (pend_v_reg)
                        begin
                            out_valid_next  = 1'b1;
                            out_kind_next   = stevq_pkg::KIND_TICK;
                            out_status_next = stevq_pkg::ST_EXPIRED;
                            out_key_next    = pend_key_reg;
                            out_last_next   = 1'b0;
                        end
                        pend_v_next   = 1'b1;
                        pend_key_next = rd_key;
                        head_next     = wrap_inc(head_reg);
                        count_next    = count_reg - CW'(1);
                        npop_next     = npop_reg + stevq_pkg::NPOP_W'(1);
                        ram_rd_en     = 1'b1;
                        ram_rd_addr   = wrap_inc(head_reg);
                    end
                    else
                    begin
                        out_valid_next  = 1'b1;
                        out_kind_next   = stevq_pkg::KIND_TICK;
                        out_status_next = pend_v_reg ? stevq_pkg::ST_EXPIRED :
                                                       stevq_pkg::ST_NONE;
                        out_key_next    = pend_v_reg ? pend_key_reg : '0;
                        out_last_next   = 1'b1;
                        pend_v_next     = 1'b0;
                        state_next      = S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            head_reg      <= '0;
            now_reg       <= '0;
            chk_v_reg     <= 1'b0;
            wv_reg        <= 1'b0;
            mv_reg        <= '0;
            pend_v_reg    <= 1'b0;
            npop_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            head_reg      <= head_next;
            now_reg       <= now_next;
            chk_v_reg     <= chk_v_next;
            wv_reg        <= wv_next;
            mv_reg        <= mv_next;
            pend_v_reg    <= pend_v_next;
            npop_reg      <= npop_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working and payload registers
    always_ff @(posedge clk)
    begin
        op_reg          <= op_next;
        key_reg         <= key_next;
        exp_reg         <= exp_next;
        chk_idx_reg     <= chk_idx_next;
        iss_cnt_reg     <= iss_cnt_next;
        iss_ptr_reg     <= iss_ptr_next;
        found_reg       <= found_next;
        found_idx_reg   <= found_idx_next;
        pos_found_reg   <= pos_found_next;
        pos_reg         <= pos_next;
        rd_ptr_reg      <= rd_ptr_next;
        wr_ptr_reg      <= wr_ptr_next;
        up_reg          <= up_next;
        pend_key_reg    <= pend_key_next;
        resp_status_reg <= resp_status_next;
        out_kind_reg    <= out_kind_next;
        out_status_reg  <= out_status_next;
        out_key_reg     <= out_key_next;
        out_last_reg    <= out_last_next;
    end

    // Table never holds more than DEPTH entries
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count beyond table depth");

    // One tick never pops more than the result limit
    assert property (@(posedge clk) disable iff (!rst_n)
        npop_reg <= stevq_pkg::NPOP_W'(stevq_pkg::MAX_RESULTS))
        else $error("too many pops on one tick");

    // A move never writes the entry it reads in the same cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT && wv_reg && mv_reg != '0) |-> (wr_ptr_reg != rd_ptr_reg))
        else $error("entry move overlaps its own read");

    // An accepted tick advances the millisecond counter by exactly one
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && cmd.ready && cmd_func == stevq_pkg::FUNC_TICK)
        |=> (now_reg == $past(now_reg) + TW'(1)))
        else $error("tick did not advance time by one");

endmodule

/* rtl/core/stevq_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
module stevq_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, data held while no read is issued
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
